// ===== hdl/mgpe_pkg.sv =====
// Shared constants, codes and types for the monochrome glyph pixel expander.
package mgpe_pkg;

    // Glyph and address geometry.
    localparam int MAX_GLYPH_BITS = 64;
    localparam int ADDRESS_BITS   = 32;

    // Width of a held glyph width, able to hold MAX_GLYPH_BITS itself.
    localparam int WID_W = $clog2(MAX_GLYPH_BITS + 1);
    // Width of the byte-within-row counter.
    localparam int BIR_W = $clog2(MAX_GLYPH_BITS / 8 + 1);
    // Width of a pixel index within a row.
    localparam int PIX_W = BIR_W + 3;

    // Field widths fixed by the port list.
    localparam int IN_ADDR_W  = 32;
    localparam int GEOM_W     = 7;
    localparam int COLOR_W    = 24;
    localparam int PITCH_W    = 16;
    localparam int FMT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTES_W    = 3;

    // Job queue between the front and back halves.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Input word codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // Pixel format codes.
    localparam logic [FMT_W-1:0] FMT_8BPP  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_16BPP = 2'd1;
    localparam logic [FMT_W-1:0] FMT_24BPP = 2'd2;
    localparam logic [FMT_W-1:0] FMT_32BPP = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH       = 2'd2;

    // One bitmap byte ready for expansion: its row address, its position
    // within the row and the set bits that fall inside the glyph width.
    typedef struct packed {
        logic [ADDRESS_BITS-1:0] row_base;
        logic [BIR_W-1:0]        byte_idx;
        logic [7:0]              mask;
    } job_t;

endpackage

// ===== hdl/mgpe_front.sv =====
// Front half: accepts words, tracks glyph geometry and emits expansion jobs.
module mgpe_front
    import mgpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic                 action,
    input  logic [IN_ADDR_W-1:0] base_address,
    input  logic [GEOM_W-1:0]    glyph_width,
    input  logic [GEOM_W-1:0]    glyph_rows,
    input  logic [7:0]           glyph_byte,
    input  logic [PITCH_W-1:0]   line_pitch,
    output logic                 job_push,
    output job_t                 job
);

    logic [ADDRESS_BITS-1:0] row_base_reg, row_base_next;
    logic [GEOM_W-1:0]       row_index_reg, row_index_next;
    logic [BIR_W-1:0]        byte_in_row_reg, byte_in_row_next;
    logic [WID_W-1:0]        width_held_reg, width_held_next;
    logic [GEOM_W-1:0]       rows_held_reg, rows_held_next;

    logic                    ignore_byte;
    logic [7:0]              in_mask;
    logic [WID_W:0]          bytes_per_row;
    logic                    row_done;

    always_comb
    begin
        in_mask = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (int'({byte_in_row_reg, 3'(j)}) < int'(width_held_reg))
            begin
                in_mask[7-j] = glyph_byte[7-j];
            end
        end
    end

    assign ignore_byte   = (width_held_reg == '0) || (row_index_reg >= rows_held_reg);
    assign bytes_per_row = ((WID_W+1)'(width_held_reg) + (WID_W+1)'(7)) >> 3;
    assign row_done      = ((WID_W+1)'(byte_in_row_reg) + (WID_W+1)'(1)) >= bytes_per_row;

    always_comb
    begin
        row_base_next    = row_base_reg;
        row_index_next   = row_index_reg;
        byte_in_row_next = byte_in_row_reg;
        width_held_next  = width_held_reg;
        rows_held_next   = rows_held_reg;
        if (in_take)
        begin
            if (action == ACT_START)
            begin
                row_base_next    = ADDRESS_BITS'(base_address);
                rows_held_next   = glyph_rows;
                row_index_next   = '0;
                byte_in_row_next = '0;
                if (int'(glyph_width) > MAX_GLYPH_BITS)
                begin
                    width_held_next = WID_W'(MAX_GLYPH_BITS);
                end
                else
                begin
                    width_held_next = WID_W'(glyph_width);
                end
            end
            else if (!ignore_byte)
            begin
                if (row_done)
                begin
                    byte_in_row_next = '0;
                    row_index_next   = row_index_reg + GEOM_W'(1);
                    row_base_next    = row_base_reg + ADDRESS_BITS'(line_pitch);
                end
                else
                begin
                    byte_in_row_next = byte_in_row_reg + BIR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_base_reg    <= '0;
            row_index_reg   <= '0;
            byte_in_row_reg <= '0;
            width_held_reg  <= '0;
            rows_held_reg   <= '0;
        end
        else
        begin
            row_base_reg    <= row_base_next;
            row_index_reg   <= row_index_next;
            byte_in_row_reg <= byte_in_row_next;
            width_held_reg  <= width_held_next;
            rows_held_reg   <= rows_held_next;
        end
    end

    // Bytes with no visible set bit only move the counters forward.
    assign job_push     = in_take && (action == ACT_BYTE) && !ignore_byte && (in_mask != '0);
    assign job.row_base = row_base_reg;
    assign job.byte_idx = byte_in_row_reg;
    assign job.mask     = in_mask;

endmodule

// ===== hdl/mgpe_job_fifo.sv =====
// Short job queue between the front and back halves.
module mgpe_job_fifo
    import mgpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic not_empty
);

    job_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0 : wr_ptr_reg + FIFO_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0 : rd_ptr_reg + FIFO_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FIFO_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");
    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

// ===== hdl/mgpe_back.sv =====
// Back half: turns each job into one pixel write per set bit, one per cycle while the result side takes them.
module mgpe_back
    import mgpe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  job_t                    job,
    output logic                    job_take,
    input  logic [FMT_W-1:0]        pixel_format,
    input  logic [COLOR_W-1:0]      foreground_color,
    input  logic                    out_pop,
    output logic                    out_valid,
    output logic [IN_ADDR_W-1:0]    write_address,
    output logic [COLOR_W-1:0]      write_data,
    output logic [BYTES_W-1:0]      write_bytes,
    output logic                    last
);

    logic                    busy_reg, busy_next;
    job_t                    cur_reg, cur_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [COLOR_W-1:0]      data_reg, data_next;
    logic [BYTES_W-1:0]      bytes_reg, bytes_next;
    logic                    last_reg, last_next;

    logic                    out_free;
    logic                    emit;
    logic [2:0]              sel_bit;
    logic                    found;
    logic [7:0]              rest_mask;
    logic [PIX_W-1:0]        pixel;
    logic [PIX_W+1:0]        offset;
    logic [COLOR_W-1:0]      color;

    // Leftmost remaining set bit is the next pixel.
    always_comb
    begin
        sel_bit = '0;
        found   = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if (!found && cur_reg.mask[7-j])
            begin
                sel_bit = 3'(j);
                found   = 1'b1;
            end
        end
    end

    assign rest_mask = cur_reg.mask & ~(8'h80 >> sel_bit);
    assign pixel     = {cur_reg.byte_idx, sel_bit};

    always_comb
    begin
        case (pixel_format)
            FMT_8BPP:  offset = (PIX_W+2)'(pixel);
            FMT_16BPP: offset = (PIX_W+2)'(pixel) << 1;
            FMT_24BPP: offset = (PIX_W+2)'(pixel) + ((PIX_W+2)'(pixel) << 1);
            default:   offset = (PIX_W+2)'(pixel) << 2;
        endcase
        case (pixel_format)
            FMT_8BPP:  color = {16'h0000, foreground_color[7:0]};
            FMT_16BPP: color = {8'h00, foreground_color[15:0]};
            default:   color = foreground_color;
        endcase
    end

    assign out_free = !out_valid_reg || out_pop;
    assign emit     = busy_reg && out_free;
    assign job_take = job_valid && (!busy_reg || (emit && (rest_mask == '0)));

    always_comb
    begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        bytes_next     = bytes_reg;
        last_next      = last_reg;
        if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next      = cur_reg.row_base + ADDRESS_BITS'(offset);
            data_next      = color;
            bytes_next     = BYTES_W'(pixel_format) + BYTES_W'(1);
            last_next      = (rest_mask == '0);
            cur_next.mask  = rest_mask;
            if (rest_mask == '0)
            begin
                busy_next = 1'b0;
            end
        end
        if (job_take)
        begin
            busy_next = 1'b1;
            cur_next  = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        addr_reg  <= addr_next;
        data_reg  <= data_next;
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign write_address = IN_ADDR_W'(addr_reg);
    assign write_data    = data_reg;
    assign write_bytes   = bytes_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_busy_has_bits : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg.mask != '0))
        else $error("pixel engine busy with an empty job");
    a_held_write_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pop) |=> (out_valid_reg && $stable(addr_reg)
            && $stable(last_reg)))
        else $error("waiting pixel write changed before it was taken");
`endif

endmodule

// ===== hdl/mono_glyph_pixel_expander_top.sv =====
// Top level of the monochrome glyph pixel expander: configuration and halves.
// Path: a bitmap byte accepted at the front is written into the job queue, then
// into the back's job register, and its pixel writes are registered on the result
// side; start words and bytes without visible set bits produce nothing.
// Throughput: one input word per cycle at the front unless the job queue is full,
// and one pixel write per cycle at the back while the result side takes them.
// Reset: asynchronous, active low; clears control state, sets 8bpp, white, pitch 640.
module mono_glyph_pixel_expander_top
    import mgpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input word queue side.
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [IN_ADDR_W-1:0]  base_address,
    input  logic [GEOM_W-1:0]     glyph_width,
    input  logic [GEOM_W-1:0]     glyph_rows,
    input  logic [7:0]            glyph_byte,
    // Result word queue side.
    output logic                  empty,
    input  logic                  pop,
    output logic [IN_ADDR_W-1:0]  write_address,
    output logic [COLOR_W-1:0]    write_data,
    output logic [BYTES_W-1:0]    write_bytes,
    output logic                  last,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]    cfg_data
);

    logic [FMT_W-1:0]   pixel_format_reg;
    logic [COLOR_W-1:0] foreground_color_reg;
    logic [PITCH_W-1:0] line_pitch_reg;

    logic in_take;
    logic job_push;
    job_t job_in;
    job_t job_out;
    logic job_full;
    logic job_valid;
    logic job_take;
    logic out_valid;

    // Configuration registers take a word on every handshake; an index past
    // the last register is accepted and has no effect.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg     <= FMT_8BPP;
            foreground_color_reg <= 24'hFF_FFFF;
            line_pitch_reg       <= 16'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PIXEL_FORMAT)
            begin
                pixel_format_reg <= cfg_data[FMT_W-1:0];
            end
            if (cfg_index == CFG_FOREGROUND_COLOR)
            begin
                foreground_color_reg <= cfg_data;
            end
            if (cfg_index == CFG_LINE_PITCH)
            begin
                line_pitch_reg <= cfg_data[PITCH_W-1:0];
            end
        end
    end

    // The front only stalls when the job queue is full, so start words and
    // empty bytes keep flowing while the back is still expanding pixels.
    assign full    = job_full;
    assign in_take = push && !job_full;

    mgpe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .action       (action),
        .base_address (base_address),
        .glyph_width  (glyph_width),
        .glyph_rows   (glyph_rows),
        .glyph_byte   (glyph_byte),
        .line_pitch   (line_pitch_reg),
        .job_push     (job_push),
        .job          (job_in)
    );

    mgpe_job_fifo u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_take),
        .pop_data  (job_out),
        .not_empty (job_valid)
    );

    // The back holds one job and a registered result word, so a waiting
    // result never blocks the queue from filling behind it.
    mgpe_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (job_valid),
        .job              (job_out),
        .job_take         (job_take),
        .pixel_format     (pixel_format_reg),
        .foreground_color (foreground_color_reg),
        .out_pop          (pop),
        .out_valid        (out_valid),
        .write_address    (write_address),
        .write_data       (write_data),
        .write_bytes      (write_bytes),
        .last             (last)
    );

    assign empty = !out_valid;

endmodule

// ===== sim/tb_mono_glyph_pixel_expander_top.sv =====
// Self-checking testbench for the monochrome glyph pixel expander top level.
`timescale 1ns / 1ps

module tb_mono_glyph_pixel_expander_top;
    import mgpe_pkg::*;

    // The run is cut off at this many cycles. The limit allows for every input
    // word causing up to eight pixel writes, each write waiting out the longest
    // receiver stall.
    localparam int CYCLE_LIMIT   = 200000;
    // Quiet cycles after the last expected write, so that start words and
    // bytes without visible set bits have left the block.
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 60;

    // One expected pixel write on the result side.
    typedef struct packed {
        logic [IN_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]   data;
        logic [BYTES_W-1:0]   nbytes;
        logic                 last_flag;
    } pixel_write_t;

    // Clock, reset and block ports. Every input is known from time zero.
    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 push         = 1'b0;
    logic                 full;
    logic                 action       = ACT_START;
    logic [IN_ADDR_W-1:0] base_address = '0;
    logic [GEOM_W-1:0]    glyph_width  = '0;
    logic [GEOM_W-1:0]    glyph_rows   = '0;
    logic [7:0]           glyph_byte   = '0;
    logic                 empty;
    logic                 pop          = 1'b0;
    logic [IN_ADDR_W-1:0] write_address;
    logic [COLOR_W-1:0]   write_data;
    logic [BYTES_W-1:0]   write_bytes;
    logic                 last;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [COLOR_W-1:0]   cfg_data     = '0;

    // Shadow of the configuration registers, starting from their reset values.
    logic [FMT_W-1:0]   fmt_shadow   = FMT_8BPP;
    logic [COLOR_W-1:0] color_shadow = 24'hFFFFFF;
    logic [PITCH_W-1:0] pitch_shadow = 16'd640;

    // Shadow of the glyph walk: current row address, row and byte within the
    // row, plus the geometry held from the last start word.
    logic [IN_ADDR_W-1:0] walk_row_base   = '0;
    logic [GEOM_W-1:0]    walk_row        = '0;
    logic [3:0]           walk_byte_in_row = '0;
    logic [GEOM_W-1:0]    held_width      = '0;
    logic [GEOM_W-1:0]    held_rows       = '0;

    // Pixel writes predicted but not yet seen on the result side.
    pixel_write_t pending_writes[$];

    int  mismatch_count = 0;
    int  words_sent     = 0;
    int  writes_checked = 0;
    int  reg_writes     = 0;
    int  cycle_count    = 0;
    // Long receiver hold-off, counted down by the result process.
    int  hold_cycles    = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;

    mono_glyph_pixel_expander_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .base_address  (base_address),
        .glyph_width   (glyph_width),
        .glyph_rows    (glyph_rows),
        .glyph_byte    (glyph_byte),
        .empty         (empty),
        .pop           (pop),
        .write_address (write_address),
        .write_data    (write_data),
        .write_bytes   (write_bytes),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a run that hangs ends here as a failure.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d pixel writes still expected",
                 cycle_count, pending_writes.size());
        $display("mono_glyph_pixel_expander_top test failed");
        $finish;
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Predicts the pixel writes caused by one accepted input word and
    // advances the shadow of the glyph walk.
    task automatic expand_glyph_word(input logic act, input logic [IN_ADDR_W-1:0] base,
                                     input logic [GEOM_W-1:0] w,
                                     input logic [GEOM_W-1:0] rows,
                                     input logic [7:0] bits);
        pixel_write_t       burst[$];
        pixel_write_t       one;
        int                 pixel;
        int                 bytes_per_row;
        logic [BYTES_W-1:0] bpp;
        logic [COLOR_W-1:0] color;

        if (act == ACT_START)
        begin
            walk_row_base    = base;
            held_width       = (w > MAX_GLYPH_BITS) ? GEOM_W'(MAX_GLYPH_BITS) : w;
            held_rows        = rows;
            walk_row         = '0;
            walk_byte_in_row = '0;
            return;
        end

        // Empty glyphs and bytes past the last row change nothing.
        if (held_width == 0 || walk_row >= held_rows)
            return;

        bpp           = BYTES_W'(fmt_shadow) + 1'b1;
        bytes_per_row = (int'(held_width) + 7) >> 3;
        case (fmt_shadow)
            FMT_8BPP:  color = {16'h0000, color_shadow[7:0]};
            FMT_16BPP: color = {8'h00, color_shadow[15:0]};
            default:   color = color_shadow;
        endcase

        // Set bits inside the width become writes; padding bits never do.
        for (int j = 0; j < 8; j++)
        begin
            pixel = int'(walk_byte_in_row) * 8 + j;
            if (pixel >= int'(held_width))
                break;
            if (bits[7 - j])
            begin
                one.addr      = walk_row_base + IN_ADDR_W'(pixel * int'(bpp));
                one.data      = color;
                one.nbytes    = bpp;
                one.last_flag = 1'b0;
                burst.push_back(one);
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].last_flag = 1'b1;
        foreach (burst[k])
            pending_writes.push_back(burst[k]);

        // The row walk advances even when the byte wrote nothing.
        if (int'(walk_byte_in_row) + 1 >= bytes_per_row)
        begin
            walk_byte_in_row = '0;
            walk_row         = walk_row + 1'b1;
            walk_row_base    = walk_row_base + IN_ADDR_W'(pitch_shadow);
        end
        else
        begin
            walk_byte_in_row = walk_byte_in_row + 1'b1;
        end
    endtask

    // Offers one input word, with an optional random gap first, and waits
    // until it is taken. Push stays high afterwards so that back-to-back
    // words follow without a gap.
    task automatic send_word(input logic act, input logic [IN_ADDR_W-1:0] base,
                             input logic [GEOM_W-1:0] w, input logic [GEOM_W-1:0] rows,
                             input logic [7:0] bits);
        int gap;

        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        action       <= act;
        base_address <= base;
        glyph_width  <= w;
        glyph_rows   <= rows;
        glyph_byte   <= bits;
        @(posedge clk);
        while (full)
            @(posedge clk);
        expand_glyph_word(act, base, w, rows, bits);
        words_sent++;
    endtask

    // A start word carries a random bitmap byte; the block must ignore it.
    task automatic start_glyph(input logic [IN_ADDR_W-1:0] base, input logic [GEOM_W-1:0] w,
                               input logic [GEOM_W-1:0] rows);
        send_word(ACT_START, base, w, rows, 8'($urandom()));
    endtask

    // A bitmap byte carries random geometry fields; the block must ignore them.
    task automatic send_bitmap_byte(input logic [7:0] bits);
        send_word(ACT_BYTE, $urandom(), GEOM_W'($urandom()), GEOM_W'($urandom()), bits);
    endtask

    // Lets the block run dry: nothing offered, every expected write seen,
    // and then a quiet stretch of SETTLE_CYCLES for words that cause no write.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic load_settings(input logic [FMT_W-1:0] fmt, input logic [COLOR_W-1:0] color,
                                 input logic [PITCH_W-1:0] pitch);
        logic [CFG_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   value;

        drain_results();
        for (int i = 0; i < 3; i++)
        begin
            case (i)
                0:       idx = CFG_PIXEL_FORMAT;
                1:       idx = CFG_FOREGROUND_COLOR;
                default: idx = CFG_LINE_PITCH;
            endcase
            case (idx)
                CFG_PIXEL_FORMAT:     value = COLOR_W'(fmt);
                CFG_FOREGROUND_COLOR: value = color;
                default:              value = COLOR_W'(pitch);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                CFG_PIXEL_FORMAT:     fmt_shadow   = value[FMT_W-1:0];
                CFG_FOREGROUND_COLOR: color_shadow = value;
                default:              pitch_shadow = value[PITCH_W-1:0];
            endcase
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    // Picks a bitmap byte, with empty and full bytes more often than chance.
    function automatic logic [7:0] pick_bitmap_byte();
        int pick;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends one random glyph: mostly a well-formed start plus its full bitmap,
    // sometimes cut short, overrun past the last row, or with zero geometry.
    task automatic send_random_glyph(output int count);
        logic [GEOM_W-1:0] w;
        logic [GEOM_W-1:0] rows;
        int                pick;
        int                eff_width;
        int                nbytes;

        pick = $urandom_range(0, 19);
        if (pick == 0)
            w = '0;
        else if (pick < 3)
            w = GEOM_W'($urandom_range(MAX_GLYPH_BITS + 1, 127));
        else if (pick < 5)
            w = GEOM_W'($urandom_range(17, MAX_GLYPH_BITS));
        else
            w = GEOM_W'($urandom_range(1, 16));

        if (pick == 5)
            rows = '0;
        else if (pick == 6)
            rows = GEOM_W'($urandom_range(65, 127));
        else if (w > 16)
            rows = GEOM_W'($urandom_range(1, 2));
        else
            rows = GEOM_W'($urandom_range(1, 5));

        eff_width = (int'(w) > MAX_GLYPH_BITS) ? MAX_GLYPH_BITS : int'(w);
        nbytes    = int'(rows) * ((eff_width + 7) >> 3);
        if (nbytes == 0)
            nbytes = 2;
        if ($urandom_range(0, 7) == 0)
            nbytes += $urandom_range(1, 2);
        if ($urandom_range(0, 9) == 0 && nbytes > 1)
            nbytes = $urandom_range(1, nbytes - 1);
        if (nbytes > 16)
            nbytes = 16;

        start_glyph($urandom(), w, rows);
        for (int k = 0; k < nbytes; k++)
            send_bitmap_byte(pick_bitmap_byte());
        count = nbytes + 1;
    endtask

    // Compares the write on the result ports with the oldest expectation.
    task automatic check_pixel_write();
        pixel_write_t want;

        if (pending_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write addr=%h data=%h bytes=%0d last=%0b",
                                      write_address, write_data, write_bytes, last));
            return;
        end
        want = pending_writes.pop_front();
        writes_checked++;
        if (write_address !== want.addr)
            report_mismatch($sformatf("write_address %h, expected %h",
                                      write_address, want.addr));
        if (write_data !== want.data)
            report_mismatch($sformatf("write_data %h, expected %h at address %h",
                                      write_data, want.data, want.addr));
        if (write_bytes !== want.nbytes)
            report_mismatch($sformatf("write_bytes %0d, expected %0d at address %h",
                                      write_bytes, want.nbytes, want.addr));
        if (last !== want.last_flag)
            report_mismatch($sformatf("last %0b, expected %0b at address %h",
                                      last, want.last_flag, want.addr));
    endtask

    // Result side: takes each word on the edge where pop is high and empty is
    // low, then decides pop for the next edge. A requested hold-off takes
    // priority over the random stall bursts.
    initial
    begin : result_sink
        int stall;

        stall = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_pixel_write();
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 6) == 0)
            begin
                stall = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Special cases at reset settings (8bpp, white, pitch 640): a byte before
    // any start, a wide glyph that saturates and wraps the address space, a
    // byte past the last row, zero width, zero rows, padding bits, a byte with
    // no set bit and a row split over two bytes.
    task automatic test_directed_cases();
        send_bitmap_byte(8'hFF);

        start_glyph(32'hFFFF_FFFC, 7'd127, 7'd1);
        send_bitmap_byte(8'hFF);
        send_bitmap_byte(8'h00);
        send_bitmap_byte(8'h80);
        send_bitmap_byte(8'h01);
        send_bitmap_byte(8'hAA);
        send_bitmap_byte(8'h55);
        send_bitmap_byte(8'hFF);
        send_bitmap_byte(8'hFF);
        send_bitmap_byte(8'hFF);

        start_glyph(32'h0000_2000, 7'd0, 7'd5);
        send_bitmap_byte(8'hFF);
        start_glyph(32'h0000_3000, 7'd5, 7'd0);
        send_bitmap_byte(8'hFF);

        start_glyph(32'h0000_4000, 7'd3, 7'd3);
        send_bitmap_byte(8'hFF);
        send_bitmap_byte(8'h00);
        send_bitmap_byte(8'hE0);

        start_glyph(32'h0000_0000, 7'd9, 7'd1);
        send_bitmap_byte(8'hFF);
        send_bitmap_byte(8'hFF);
    endtask

    // Random glyphs under each pixel format, with the color and pitch
    // extremes among the settings and idling switched per side.
    task automatic test_format_sweep();
        int sent;
        int n;

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: load_settings(FMT_8BPP, 24'h000000, 16'd1);
                1: load_settings(FMT_16BPP, 24'hFFFFFF, 16'hFFFF);
                2: load_settings(FMT_24BPP, 24'($urandom()),
                                 PITCH_W'($urandom_range(1, 65535)));
                default: load_settings(FMT_32BPP, 24'($urandom()), 16'd640);
            endcase
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 1);
            sent = 0;
            while (sent < 22)
            begin
                send_random_glyph(n);
                sent += n;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while a full-width glyph of
    // solid bytes keeps coming, so the block fills and raises full.
    task automatic test_backpressure();
        hold_cycles = 300;
        start_glyph($urandom(), 7'd64, 7'd2);
        for (int k = 0; k < 16; k++)
            send_bitmap_byte(8'hFF);
    endtask

    // The sender pauses until every expected write has come, then resumes
    // with the same glyph walk.
    task automatic test_sender_pause();
        start_glyph($urandom(), 7'd16, 7'd3);
        send_bitmap_byte(pick_bitmap_byte());
        send_bitmap_byte(pick_bitmap_byte());
        send_bitmap_byte(pick_bitmap_byte());
        drain_results();
        send_bitmap_byte(pick_bitmap_byte());
        send_bitmap_byte(pick_bitmap_byte());
        send_bitmap_byte(pick_bitmap_byte());
        send_bitmap_byte(8'hFF);
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_unthrottled_tail();
        int sent;
        int n;

        load_settings(FMT_24BPP, 24'h00FF00, 16'd320);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        sent = 0;
        while (sent < 20)
        begin
            send_random_glyph(n);
            sent += n;
        end
    endtask

    initial
    begin : test_sequence
        int idle_wait;

        // Reset is held low from time zero and released on a clock edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_format_sweep();
        test_backpressure();
        test_sender_pause();
        test_unthrottled_tail();

        // Wait for the last writes, with a bound, then let the pipeline settle
        // so that a stray write would still be caught.
        push <= 1'b0;
        idle_wait = 0;
        while (pending_writes.size() != 0 && idle_wait < 20000)
        begin
            @(posedge clk);
            idle_wait++;
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (pending_writes.size() != 0)
            report_mismatch($sformatf("%0d expected pixel writes never arrived",
                                      pending_writes.size()));

        $display("Run covered %0d input words and %0d checked pixel writes, with %0d register",
                 words_sent, writes_checked, reg_writes);
        $display("writes over all four pixel formats, backpressure and sender pauses; %0d errors",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("mono_glyph_pixel_expander_top test passed");
        else
            $display("mono_glyph_pixel_expander_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mgpe_pkg.sv
hdl/mgpe_front.sv
hdl/mgpe_job_fifo.sv
hdl/mgpe_back.sv
hdl/mono_glyph_pixel_expander_top.sv
sim/tb_mono_glyph_pixel_expander_top.sv
